>>> hw/rtl/bsa_pkg.sv
// shared types, codes and defaults for the banker's safety allocator
`timescale 1ns / 1ps

package bsa_pkg;

	localparam int DEF_MAX_PROCESSES = 16;
	localparam int DEF_AMOUNT_WIDTH  = 8;
	localparam int KINDS             = 3;
	localparam int OPCODE_WIDTH      = 2;
	localparam int STATUS_WIDTH      = 3;

	typedef enum logic [OPCODE_WIDTH-1:0] {
		OP_LOAD    = 2'd0,
		OP_AVAIL   = 2'd1,
		OP_REQUEST = 2'd2,
		OP_CHECK   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_OK     = 3'd0,
		ST_NEED   = 3'd1,
		ST_AVAIL  = 3'd2,
		ST_UNSAFE = 3'd3,
		ST_BADROW = 3'd4
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic load_row;
		logic set_avail;
		logic req_eval;
		logic chk_init;
		logic scan;
		logic rollback;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		opcode_t opcode;
		logic    req_ok;
		logic    scan_stop;
		logic    scan_safe;
	} dp_stat_t;

endpackage

>>> hw/rtl/bsa_if.sv
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps

interface bsa_in_if #(
	parameter int ID_WIDTH     = 4,
	parameter int AMOUNT_WIDTH = bsa_pkg::DEF_AMOUNT_WIDTH
);
	logic                               valid;
	logic                               ready;
	logic [bsa_pkg::OPCODE_WIDTH-1:0]   opcode;
	logic [ID_WIDTH-1:0]                process_id;
	logic [AMOUNT_WIDTH-1:0]            amount_a;
	logic [AMOUNT_WIDTH-1:0]            amount_b;
	logic [AMOUNT_WIDTH-1:0]            amount_c;
	logic [AMOUNT_WIDTH-1:0]            max_a;
	logic [AMOUNT_WIDTH-1:0]            max_b;
	logic [AMOUNT_WIDTH-1:0]            max_c;

	modport source (
		output valid, opcode, process_id, amount_a, amount_b, amount_c, max_a, max_b, max_c,
		input  ready
	);
	modport sink (
		input  valid, opcode, process_id, amount_a, amount_b, amount_c, max_a, max_b, max_c,
		output ready
	);
endinterface

interface bsa_out_if;
	logic                               valid;
	logic                               ready;
	logic [bsa_pkg::STATUS_WIDTH-1:0]   status;
	logic                               granted;

	modport source (output valid, status, granted, input ready);
	modport sink (input valid, status, granted, output ready);
endinterface

>>> hw/rtl/bsa_ctrl.sv
// sequencing state machine for the banker's safety allocator
`timescale 1ns / 1ps

module bsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bsa_pkg::dp_cmd_t  cmd,
	input  bsa_pkg::dp_stat_t stat
);
	import bsa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_CHK_INIT,
		S_SCAN,
		S_ROLLBACK,
		S_POST
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:     cmd.capture = in_valid;
			S_DECODE: begin
				unique case (stat.opcode)
					OP_LOAD:    cmd.load_row  = 1'b1;
					OP_AVAIL:   cmd.set_avail = 1'b1;
					OP_REQUEST: cmd.req_eval  = 1'b1;
					OP_CHECK:   cmd.req_eval  = 1'b0;
				endcase
			end
			S_CHK_INIT: cmd.chk_init = 1'b1;
			S_SCAN:     cmd.scan     = 1'b1;
			S_ROLLBACK: cmd.rollback = 1'b1;
			S_POST:     cmd.out_load = out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_POST && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (stat.opcode)
						OP_LOAD:    state_q <= S_POST;
						OP_AVAIL:   state_q <= S_POST;
						OP_REQUEST: state_q <= stat.req_ok ? S_CHK_INIT : S_POST;
						OP_CHECK:   state_q <= S_CHK_INIT;
					endcase
				end
				S_CHK_INIT: state_q <= S_SCAN;
				S_SCAN: begin
					if (stat.scan_stop) begin
						// an unsafe tentative grant has to be undone
						if (stat.opcode == OP_REQUEST && !stat.scan_safe) begin
							state_q <= S_ROLLBACK;
						end else begin
							state_q <= S_POST;
						end
					end
				end
				S_ROLLBACK: state_q <= S_POST;
				S_POST: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/bsa_datapath.sv
// row memory, available and work vectors, safety scan and result registers
`timescale 1ns / 1ps

module bsa_datapath #(
	parameter int MAX_PROCESSES = bsa_pkg::DEF_MAX_PROCESSES,
	parameter int AMOUNT_WIDTH  = bsa_pkg::DEF_AMOUNT_WIDTH,
	parameter int ID_WIDTH      = $clog2(MAX_PROCESSES),
	parameter int COUNT_WIDTH   = $clog2(MAX_PROCESSES + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [COUNT_WIDTH-1:0]           cfg_data,
	input  logic [bsa_pkg::OPCODE_WIDTH-1:0] opcode,
	input  logic [ID_WIDTH-1:0]              process_id,
	input  logic [AMOUNT_WIDTH-1:0]          amount_a,
	input  logic [AMOUNT_WIDTH-1:0]          amount_b,
	input  logic [AMOUNT_WIDTH-1:0]          amount_c,
	input  logic [AMOUNT_WIDTH-1:0]          max_a,
	input  logic [AMOUNT_WIDTH-1:0]          max_b,
	input  logic [AMOUNT_WIDTH-1:0]          max_c,
	input  bsa_pkg::dp_cmd_t                 cmd,
	output bsa_pkg::dp_stat_t                stat,
	output logic [bsa_pkg::STATUS_WIDTH-1:0] status,
	output logic                             granted
);
	import bsa_pkg::*;

	typedef logic [KINDS-1:0][AMOUNT_WIDTH-1:0] vec_t;

	typedef struct packed {
		vec_t alloc;
		vec_t need;
	} row_t;

	typedef struct packed {
		opcode_t               opcode;
		logic [ID_WIDTH-1:0]   pid;
		vec_t                  amt;
		vec_t                  mx;
	} item_t;

	row_t mem [MAX_PROCESSES];

	item_t                   item_q;
	vec_t                    avail_q;
	vec_t                    work_q;
	vec_t                    work_nxt;
	row_t                    rd_row_q;
	row_t                    orig_q;
	row_t                    wr_row;
	logic                    wr_en;
	logic [ID_WIDTH-1:0]     rd_addr;
	logic [ID_WIDTH-1:0]     scan_row_q;
	logic [ID_WIDTH-1:0]     eval_row_s1;
	logic                    eval_vld_s1;
	logic [ID_WIDTH-1:0]     pass_q;
	logic [MAX_PROCESSES-1:0] done_q;
	logic [COUNT_WIDTH-1:0]  count_q;
	logic [COUNT_WIDTH-1:0]  eff_n;
	logic [COUNT_WIDTH-1:0]  last_idx;
	logic [COUNT_WIDTH-1:0]  finished_q;
	logic [COUNT_WIDTH-1:0]  finished_nxt;
	logic                    progress_q;
	status_t                 res_status_q;
	logic                    res_granted_q;
	status_t                 out_status_q;
	logic                    out_granted_q;

	logic load_bad;
	logic req_bad;
	logic over_need;
	logic over_avail;
	logic req_ok;
	logic fits;
	logic scan_last;
	logic pass_end;
	logic all_done;
	logic progress_nxt;
	logic scan_stop;

	// rows taking part: zero counts as one, clamp at the table depth
	always_comb begin
		if (count_q == '0) begin
			eff_n = COUNT_WIDTH'(1);
		end else if (count_q > COUNT_WIDTH'(MAX_PROCESSES)) begin
			eff_n = COUNT_WIDTH'(MAX_PROCESSES);
		end else begin
			eff_n = count_q;
		end
	end
	assign last_idx = eff_n - COUNT_WIDTH'(1);

	always_comb begin
		load_bad   = COUNT_WIDTH'(item_q.pid) >= COUNT_WIDTH'(MAX_PROCESSES);
		req_bad    = COUNT_WIDTH'(item_q.pid) >= eff_n;
		over_need  = 1'b0;
		over_avail = 1'b0;
		for (int k = 0; k < KINDS; k++) begin
			if (item_q.mx[k] < item_q.amt[k]) load_bad = 1'b1;
			if (item_q.amt[k] > rd_row_q.need[k]) over_need = 1'b1;
			if (item_q.amt[k] > avail_q[k]) over_avail = 1'b1;
		end
		req_ok = !req_bad && !over_need && !over_avail;
	end

	// scan evaluation of the row read in the previous cycle
	always_comb begin
		logic [AMOUNT_WIDTH:0] sum;
		fits = eval_vld_s1 && !done_q[eval_row_s1];
		for (int k = 0; k < KINDS; k++) begin
			if (rd_row_q.need[k] > work_q[k]) fits = 1'b0;
			sum = {1'b0, work_q[k]} + {1'b0, rd_row_q.alloc[k]};
			work_nxt[k] = sum[AMOUNT_WIDTH] ? {AMOUNT_WIDTH{1'b1}} : sum[AMOUNT_WIDTH-1:0];
		end
	end

	assign finished_nxt = finished_q + COUNT_WIDTH'(fits);
	assign scan_last    = COUNT_WIDTH'(scan_row_q) == last_idx;
	assign pass_end     = eval_vld_s1 && (COUNT_WIDTH'(eval_row_s1) == last_idx);
	assign all_done     = finished_nxt == eff_n;
	assign progress_nxt = progress_q || fits;
	// a pass without progress can never make any later
	assign scan_stop    = pass_end && (all_done || !progress_nxt ||
		COUNT_WIDTH'(pass_q) == last_idx);

	assign stat.opcode    = item_q.opcode;
	assign stat.req_ok    = req_ok;
	assign stat.scan_stop = scan_stop;
	assign stat.scan_safe = all_done;

	assign rd_addr = cmd.capture ? process_id : scan_row_q;

	always_comb begin
		wr_en  = 1'b0;
		wr_row = orig_q;
		if (cmd.load_row) begin
			wr_en = !load_bad;
			for (int k = 0; k < KINDS; k++) begin
				wr_row.alloc[k] = item_q.amt[k];
				wr_row.need[k]  = item_q.mx[k] - item_q.amt[k];
			end
		end else if (cmd.req_eval) begin
			wr_en = req_ok;
			for (int k = 0; k < KINDS; k++) begin
				wr_row.alloc[k] = rd_row_q.alloc[k] + item_q.amt[k];
				wr_row.need[k]  = rd_row_q.need[k] - item_q.amt[k];
			end
		end else if (cmd.rollback) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[item_q.pid] <= wr_row;
		end
		rd_row_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= COUNT_WIDTH'(1);
			avail_q     <= '0;
			eval_vld_s1 <= 1'b0;
			scan_row_q  <= '0;
			pass_q      <= '0;
			done_q      <= '0;
			finished_q  <= '0;
			progress_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (cmd.set_avail) begin
				avail_q <= item_q.amt;
			end else if (cmd.req_eval && req_ok) begin
				for (int k = 0; k < KINDS; k++) begin
					avail_q[k] <= avail_q[k] - item_q.amt[k];
				end
			end else if (cmd.rollback) begin
				for (int k = 0; k < KINDS; k++) begin
					avail_q[k] <= avail_q[k] + item_q.amt[k];
				end
			end

			if (cmd.chk_init) begin
				eval_vld_s1 <= 1'b0;
				scan_row_q  <= '0;
				pass_q      <= '0;
				done_q      <= '0;
				finished_q  <= '0;
				progress_q  <= 1'b0;
			end else begin
				if (cmd.scan) begin
					scan_row_q  <= scan_last ? '0 : scan_row_q + ID_WIDTH'(1);
					eval_vld_s1 <= !scan_stop;
				end else begin
					eval_vld_s1 <= 1'b0;
				end
				if (fits) begin
					done_q[eval_row_s1] <= 1'b1;
					finished_q          <= finished_nxt;
				end
				if (pass_end) begin
					pass_q     <= pass_q + ID_WIDTH'(1);
					progress_q <= 1'b0;
				end else if (fits) begin
					progress_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q.opcode <= opcode_t'(opcode);
			item_q.pid    <= process_id;
			item_q.amt    <= {amount_c, amount_b, amount_a};
			item_q.mx     <= {max_c, max_b, max_a};
		end
		eval_row_s1 <= scan_row_q;
		if (cmd.chk_init) begin
			work_q <= avail_q;
		end else if (fits) begin
			work_q <= work_nxt;
		end
		if (cmd.req_eval) begin
			orig_q <= rd_row_q;
		end

		if (cmd.load_row) begin
			res_status_q  <= load_bad ? ST_BADROW : ST_OK;
			res_granted_q <= 1'b0;
		end else if (cmd.set_avail) begin
			res_status_q  <= ST_OK;
			res_granted_q <= 1'b0;
		end else if (cmd.req_eval) begin
			res_granted_q <= 1'b0;
			priority if (req_bad) begin
				res_status_q <= ST_BADROW;
			end else if (over_need) begin
				res_status_q <= ST_NEED;
			end else if (over_avail) begin
				res_status_q <= ST_AVAIL;
			end else begin
				res_status_q <= ST_OK;
			end
		end else if (cmd.scan && scan_stop) begin
			res_status_q  <= all_done ? ST_OK : ST_UNSAFE;
			res_granted_q <= all_done;
		end

		if (cmd.out_load) begin
			out_status_q  <= res_status_q;
			out_granted_q <= res_granted_q;
		end
	end

	assign status  = out_status_q;
	assign granted = out_granted_q;

endmodule

>>> hw/rtl/bankers_safety_allocator.sv
// top level of the banker's safety allocator
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    opcode, process_id, amount_a..c, max_a..c
//  result   out  valid/ready    status, granted
//  cfg      in   cfg_we         cfg_data = process_count
//
// load row and set available: capture, decode, then post the result
// safety check: capture, decode, scan init and the scan, then post; N = active rows;
//   the scan reads one row of the row memory per cycle in at most N passes;
//   a request that turns out unsafe adds a rollback step before the post
// reset: process_count 1, available zero, row memory is not cleared
// a new item is taken while a result waits; its own result waits until the
//   result register has been transferred
`timescale 1ns / 1ps

module bankers_safety_allocator #(
	parameter int MAX_PROCESSES = bsa_pkg::DEF_MAX_PROCESSES,
	parameter int AMOUNT_WIDTH  = bsa_pkg::DEF_AMOUNT_WIDTH,
	localparam int COUNT_WIDTH  = $clog2(MAX_PROCESSES + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [COUNT_WIDTH-1:0] cfg_data,
	bsa_in_if.sink                 item,
	bsa_out_if.source              result
);
	import bsa_pkg::*;

	localparam int ID_WIDTH = $clog2(MAX_PROCESSES);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	bsa_datapath #(
		.MAX_PROCESSES (MAX_PROCESSES),
		.AMOUNT_WIDTH  (AMOUNT_WIDTH),
		.ID_WIDTH      (ID_WIDTH),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.opcode     (item.opcode),
		.process_id (item.process_id),
		.amount_a   (item.amount_a),
		.amount_b   (item.amount_b),
		.amount_c   (item.amount_c),
		.max_a      (item.max_a),
		.max_b      (item.max_b),
		.max_c      (item.max_c),
		.cmd        (cmd),
		.stat       (stat),
		.status     (result.status),
		.granted    (result.granted)
	);

endmodule

>>> tb/sv/bankers_safety_allocator_test.sv
// self-checking testbench for the banker's safety allocator, with a predictor and random traffic
`timescale 1ns / 1ps

module bankers_safety_allocator_test;
	import bsa_pkg::*;

	localparam int NPROC = DEF_MAX_PROCESSES;
	localparam int AW = DEF_AMOUNT_WIDTH;
	localparam int IW = $clog2(NPROC);
	localparam int CW = $clog2(NPROC + 1);
	localparam int TOP_AMOUNT = (1 << AW) - 1;
	localparam int ITEM_TARGET = 1450;
	localparam longint CYCLE_LIMIT = 2500000;

	typedef logic [KINDS-1:0][AW-1:0] triple_t;

	typedef struct packed {
		opcode_t        op;
		logic [IW-1:0]  pid;
		triple_t        amt;
		triple_t        mx;
	} bank_item_t;

	typedef struct packed {
		status_t status;
		logic    granted;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CW-1:0] cfg_data;

	bsa_in_if #(.ID_WIDTH(IW), .AMOUNT_WIDTH(AW)) item_bus ();
	bsa_out_if result_bus ();

	bankers_safety_allocator #(.MAX_PROCESSES(NPROC), .AMOUNT_WIDTH(AW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.item(item_bus.sink),
		.result(result_bus.source)
	);

	// predictor copy of the allocator state
	triple_t free_units;
	triple_t alloc_rows [NPROC];
	triple_t need_rows [NPROC];
	logic [CW-1:0] proc_count;
	verdict_t pending_verdicts [$];

	int errors;
	int items_sent;
	int results_seen;
	int granted_seen;
	int hold_cycles;
	int op_tally [4];
	int status_tally [8];
	bit gaps_on;
	longint cycle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int rows_in_play();
		int n;
		n = proc_count;
		if (n == 0) n = 1;
		if (n > NPROC) n = NPROC;
		return n;
	endfunction

	function automatic bit system_is_safe();
		int n;
		int finished;
		int s;
		bit fits;
		bit [NPROC-1:0] done;
		triple_t work;
		n = rows_in_play();
		finished = 0;
		done = '0;
		work = free_units;
		for (int pass = 0; pass < n; pass++) begin
			for (int r = 0; r < n; r++) begin
				if (!done[r]) begin
					fits = 1'b1;
					for (int k = 0; k < KINDS; k++)
						if (need_rows[r][k] > work[k]) fits = 1'b0;
					if (fits) begin
						// work vector saturates at the largest amount
						for (int k = 0; k < KINDS; k++) begin
							s = int'(work[k]) + int'(alloc_rows[r][k]);
							work[k] = (s > TOP_AMOUNT) ? AW'(TOP_AMOUNT) : AW'(s);
						end
						done[r] = 1'b1;
						finished++;
					end
				end
			end
			if (finished == n) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic verdict_t predict_verdict(bank_item_t it);
		verdict_t v;
		bit bad;
		bit over_need;
		bit over_avail;
		v.status = ST_OK;
		v.granted = 1'b0;
		case (it.op)
			OP_LOAD: begin
				bad = 1'b0;
				for (int k = 0; k < KINDS; k++)
					if (it.mx[k] < it.amt[k]) bad = 1'b1;
				if (bad) begin
					v.status = ST_BADROW;
				end else begin
					for (int k = 0; k < KINDS; k++) begin
						alloc_rows[it.pid][k] = it.amt[k];
						need_rows[it.pid][k] = it.mx[k] - it.amt[k];
					end
				end
			end
			OP_AVAIL: begin
				free_units = it.amt;
			end
			OP_REQUEST: begin
				if (int'(it.pid) >= rows_in_play()) begin
					v.status = ST_BADROW;
				end else begin
					over_need = 1'b0;
					over_avail = 1'b0;
					for (int k = 0; k < KINDS; k++) begin
						if (it.amt[k] > need_rows[it.pid][k]) over_need = 1'b1;
						if (it.amt[k] > free_units[k]) over_avail = 1'b1;
					end
					if (over_need) begin
						v.status = ST_NEED;
					end else if (over_avail) begin
						v.status = ST_AVAIL;
					end else begin
						for (int k = 0; k < KINDS; k++) begin
							free_units[k] = free_units[k] - it.amt[k];
							alloc_rows[it.pid][k] = alloc_rows[it.pid][k] + it.amt[k];
							need_rows[it.pid][k] = need_rows[it.pid][k] - it.amt[k];
						end
						if (system_is_safe()) begin
							v.granted = 1'b1;
						end else begin
							// tentative grant undone
							for (int k = 0; k < KINDS; k++) begin
								free_units[k] = free_units[k] + it.amt[k];
								alloc_rows[it.pid][k] = alloc_rows[it.pid][k] - it.amt[k];
								need_rows[it.pid][k] = need_rows[it.pid][k] + it.amt[k];
							end
							v.status = ST_UNSAFE;
						end
					end
				end
			end
			default: begin
				if (system_is_safe()) v.granted = 1'b1;
				else v.status = ST_UNSAFE;
			end
		endcase
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic triple_t trio(int a, int b, int c);
		triple_t t;
		t[0] = AW'(a);
		t[1] = AW'(b);
		t[2] = AW'(c);
		return t;
	endfunction

	function automatic triple_t rand_trio(int limit);
		triple_t t;
		int lim;
		lim = (limit > TOP_AMOUNT) ? TOP_AMOUNT : limit;
		for (int k = 0; k < KINDS; k++) t[k] = AW'($urandom_range(0, lim));
		return t;
	endfunction

	function automatic bank_item_t make_item(opcode_t op, int pid, triple_t amt, triple_t mx);
		bank_item_t it;
		it.op = op;
		it.pid = IW'(pid);
		it.amt = amt;
		it.mx = mx;
		return it;
	endfunction

	// well-formed row: max never below allocation
	function automatic bank_item_t rand_row(int pid, int scale);
		bank_item_t it;
		int m;
		it = make_item(OP_LOAD, pid, rand_trio(scale), '0);
		for (int k = 0; k < KINDS; k++) begin
			m = int'(it.amt[k]) + $urandom_range(0, scale);
			it.mx[k] = (m > TOP_AMOUNT) ? AW'(TOP_AMOUNT) : AW'(m);
		end
		return it;
	endfunction

	function automatic bank_item_t rand_request(int scale);
		bank_item_t it;
		int pid;
		bit within_need;
		if ($urandom_range(0, 9) == 0) pid = $urandom_range(0, NPROC - 1);
		else pid = $urandom_range(0, rows_in_play() - 1);
		within_need = ($urandom_range(0, 3) != 0);
		it = make_item(OP_REQUEST, pid, rand_trio(scale), rand_trio(TOP_AMOUNT));
		if (within_need)
			for (int k = 0; k < KINDS; k++)
				it.amt[k] = AW'($urandom_range(0, need_rows[pid][k]));
		return it;
	endfunction

	function automatic bank_item_t noise_item();
		return make_item(opcode_t'($urandom_range(0, 3)), $urandom_range(0, NPROC - 1),
			rand_trio(TOP_AMOUNT), rand_trio(TOP_AMOUNT));
	endfunction

	function automatic int pick_scale();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 7;
		if (r < 90) return 31;
		return TOP_AMOUNT;
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 5);
		if (r < 85) return $urandom_range(6, NPROC);
		if (r < 92) return 0;
		return $urandom_range(NPROC + 1, (1 << CW) - 1);
	endfunction

	task automatic send_item(bank_item_t it);
		int gap;
		verdict_t v;
		gap = pick_gap();
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.opcode <= it.op;
		item_bus.process_id <= it.pid;
		item_bus.amount_a <= it.amt[0];
		item_bus.amount_b <= it.amt[1];
		item_bus.amount_c <= it.amt[2];
		item_bus.max_a <= it.mx[0];
		item_bus.max_b <= it.mx[1];
		item_bus.max_c <= it.mx[2];
		@(posedge clk);
		while (item_bus.ready !== 1'b1) @(posedge clk);
		// transfer at this edge
		v = predict_verdict(it);
		pending_verdicts.push_back(v);
		items_sent++;
		op_tally[int'(it.op)]++;
		status_tally[int'(v.status)]++;
		if (v.granted) granted_seen++;
	endtask

	// sender pauses until every result is back and the block is idle
	task automatic settle();
		item_bus.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(int value);
		cfg_we <= 1'b1;
		cfg_data <= CW'(value);
		@(posedge clk);
		proc_count = CW'(value);
		cfg_we <= 1'b0;
	endtask

	// every row gets defined contents before anything reads the table
	task automatic test_fill_table();
		for (int r = 0; r < NPROC; r++) begin
			if (r == 0) send_item(make_item(OP_LOAD, r, trio(0, 0, 0), trio(0, 0, 0)));
			else if (r == NPROC - 3)
				send_item(make_item(OP_LOAD, r, trio(0, 0, 0),
					trio(TOP_AMOUNT, TOP_AMOUNT, TOP_AMOUNT)));
			else if (r == NPROC - 1)
				send_item(make_item(OP_LOAD, r, trio(TOP_AMOUNT, TOP_AMOUNT, TOP_AMOUNT),
					trio(TOP_AMOUNT, TOP_AMOUNT, TOP_AMOUNT)));
			else send_item(rand_row(r, 3));
		end
	endtask

	task automatic test_special_cases();
		// max below allocation in one kind only
		send_item(make_item(OP_LOAD, 3, trio(1, 1, 5), trio(9, 9, 4)));
		send_item(make_item(OP_AVAIL, 0, trio(0, 0, 0), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_CHECK, 0, rand_trio(TOP_AMOUNT), rand_trio(TOP_AMOUNT)));
		// row outside the active set
		send_item(make_item(OP_REQUEST, 5, trio(0, 0, 0), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_REQUEST, 0, trio(1, 0, 0), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_LOAD, 0, trio(2, 2, 2), trio(6, 6, 6)));
		send_item(make_item(OP_AVAIL, 0, trio(3, 3, 3), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_REQUEST, 0, trio(0, 0, 4), rand_trio(TOP_AMOUNT)));
		// fits need and available but leaves the row stuck, so it is rolled back
		send_item(make_item(OP_REQUEST, 0, trio(1, 1, 1), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_AVAIL, 0, trio(4, 4, 4), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_REQUEST, 0, trio(2, 2, 2), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_CHECK, 0, rand_trio(TOP_AMOUNT), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_AVAIL, 0, trio(1, 1, 1), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_CHECK, 0, rand_trio(TOP_AMOUNT), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_AVAIL, 0, trio(TOP_AMOUNT, TOP_AMOUNT, TOP_AMOUNT),
			rand_trio(TOP_AMOUNT)));
		settle();
		write_count(NPROC);
		// releases of full rows overflow the work vector
		send_item(make_item(OP_CHECK, 0, rand_trio(TOP_AMOUNT), rand_trio(TOP_AMOUNT)));
		send_item(make_item(OP_REQUEST, NPROC - 3, trio(TOP_AMOUNT, TOP_AMOUNT, TOP_AMOUNT),
			rand_trio(TOP_AMOUNT)));
		settle();
		write_count(0);
		send_item(make_item(OP_REQUEST, 1, trio(0, 0, 0), rand_trio(TOP_AMOUNT)));
		settle();
		write_count((1 << CW) - 1);
		send_item(make_item(OP_REQUEST, NPROC - 1, trio(0, 0, 0), rand_trio(TOP_AMOUNT)));
	endtask

	task automatic run_scenario(int count_value, int ops);
		int scale;
		int pick;
		bank_item_t it;
		settle();
		write_count(count_value);
		scale = pick_scale();
		for (int r = 0; r < rows_in_play(); r++) send_item(rand_row(r, scale));
		send_item(make_item(OP_AVAIL, $urandom_range(0, NPROC - 1), rand_trio(scale * 2),
			rand_trio(TOP_AMOUNT)));
		for (int i = 0; i < ops; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) it = rand_request(scale);
			else if (pick < 75)
				it = make_item(OP_CHECK, $urandom_range(0, NPROC - 1), rand_trio(TOP_AMOUNT),
					rand_trio(TOP_AMOUNT));
			else if (pick < 85) it = rand_row($urandom_range(0, rows_in_play() - 1), scale);
			else if (pick < 92)
				it = make_item(OP_AVAIL, $urandom_range(0, NPROC - 1), rand_trio(scale),
					rand_trio(TOP_AMOUNT));
			else it = noise_item();
			send_item(it);
		end
	endtask

	// results are held back while items keep coming, so the block backs up
	task automatic test_result_backlog();
		settle();
		write_count(3);
		hold_cycles = 400;
		for (int i = 0; i < 40; i++) begin
			case ($urandom_range(0, 3))
				0: send_item(rand_row($urandom_range(0, 2), 7));
				1: send_item(make_item(OP_AVAIL, 0, rand_trio(15), rand_trio(TOP_AMOUNT)));
				2: send_item(rand_request(7));
				default: send_item(make_item(OP_CHECK, 0, rand_trio(TOP_AMOUNT),
					rand_trio(TOP_AMOUNT)));
			endcase
		end
		settle();
	endtask

	task automatic test_steady_stream();
		gaps_on = 1'b0;
		run_scenario(4, 110);
		settle();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_scenarios();
		while (items_sent < ITEM_TARGET) run_scenario(pick_count(), $urandom_range(10, 25));
	endtask

	// result receiver with random stalls and an occasional long hold-off
	initial begin : result_receiver
		int stall;
		stall = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				result_bus.ready <= 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				result_bus.ready <= 1'b0;
				stall--;
			end else begin
				result_bus.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			results_seen++;
			if (pending_verdicts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result at cycle %0d: status %0d granted %0b",
						cycle_count, result_bus.status, result_bus.granted);
			end else begin
				want = pending_verdicts.pop_front();
				if (result_bus.status !== want.status || result_bus.granted !== want.granted) begin
					errors++;
					if (errors <= 10)
						$display("mismatch on result %0d: expected status %0d granted %0b, got status %0d granted %0b",
							results_seen, want.status, want.granted,
							result_bus.status, result_bus.granted);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_verdicts.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		granted_seen = 0;
		hold_cycles = 0;
		cycle_count = 0;
		gaps_on = 1'b1;
		foreach (op_tally[i]) op_tally[i] = 0;
		foreach (status_tally[i]) status_tally[i] = 0;
		proc_count = CW'(1);
		free_units = '0;
		foreach (alloc_rows[i]) begin
			alloc_rows[i] = '0;
			need_rows[i] = '0;
		end
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		item_bus.valid <= 1'b0;
		item_bus.opcode <= '0;
		item_bus.process_id <= '0;
		item_bus.amount_a <= '0;
		item_bus.amount_b <= '0;
		item_bus.amount_c <= '0;
		item_bus.max_a <= '0;
		item_bus.max_b <= '0;
		item_bus.max_c <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_table();
		test_special_cases();
		test_result_backlog();
		test_steady_stream();
		test_random_scenarios();
		settle();
		repeat (300) @(posedge clk);
		$display("covered %0d items: %0d row loads, %0d available sets, %0d requests, %0d checks",
			items_sent, op_tally[OP_LOAD], op_tally[OP_AVAIL], op_tally[OP_REQUEST],
			op_tally[OP_CHECK]);
		$display("outcomes: %0d ok (%0d granted), %0d over need, %0d over available, %0d unsafe, %0d bad row",
			status_tally[ST_OK], granted_seen, status_tally[ST_NEED], status_tally[ST_AVAIL],
			status_tally[ST_UNSAFE], status_tally[ST_BADROW]);
		if (errors == 0 && pending_verdicts.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/bsa_pkg.sv
hw/rtl/bsa_if.sv
hw/rtl/bsa_ctrl.sv
hw/rtl/bsa_datapath.sv
hw/rtl/bankers_safety_allocator.sv
tb/sv/bankers_safety_allocator_test.sv
